### rtl/gcs_pkg.sv
// ----------------------------------------------------------------------------
// gcs_pkg: shared types and constants of the gear calibration sequencer
// event and result payloads, phase and command codes, register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package gcs_pkg;

	localparam int DAY_W      = 16;
	localparam int GEAR_W     = 4;
	localparam int CMD_W      = 2;
	localparam int PHASE_W    = 2;
	localparam int MIN_W      = 8;
	localparam int TRY_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// event kinds
	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GEAR    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd3;

	// sequencer phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
	localparam logic [PHASE_W-1:0] PH_REQUESTED = 2'd1;
	localparam logic [PHASE_W-1:0] PH_SENT      = 2'd2;
	localparam logic [PHASE_W-1:0] PH_RUNNING   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES    = 2'd1;

	localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = 8'd30;
	localparam logic [TRY_W-1:0]  MAX_TRIES_RST    = 4'd4;
	localparam logic [TRY_W-1:0]  TRY_SAT          = '1;
	localparam logic [GEAR_W-1:0] GEAR_RUNNING     = 4'd0;
	localparam logic [GEAR_W-1:0] GEAR_DONE        = 4'd1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [GEAR_W-1:0] gear;
		logic [DAY_W-1:0]  day;
		logic              day_is_number;
	} item_t;

	typedef struct packed {
		logic               send_calibrate;
		logic               publish_day_valid;
		logic [DAY_W-1:0]   completed_day;
		logic               block_calibration;
		logic               request_accepted;
		logic [PHASE_W-1:0] phase;
	} result_t;

	typedef struct packed {
		logic [MIN_W-1:0] min_interval_days;
		logic [TRY_W-1:0] max_tries;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/gcs_core.sv
// ----------------------------------------------------------------------------
// gcs_core: sequencer state and per-event next-state logic
// holds phase, last completed day and attempt count; builds one result
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire gcs_pkg::item_t item,
	input  wire gcs_pkg::cfg_t  cfg,
	output gcs_pkg::result_t    result
);

	logic [gcs_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [gcs_pkg::DAY_W-1:0]   last_day_q, last_day_d;
	logic [gcs_pkg::TRY_W-1:0]   try_q, try_d;
	logic                        send, publish, block, accepted;
	logic [gcs_pkg::DAY_W:0]     age;
	logic                        age_ok;

	// signed age: borrow out means the day lies before the stored one
	assign age    = {1'b0, item.day} - {1'b0, last_day_q};
	assign age_ok = !age[gcs_pkg::DAY_W] &&
		(age[gcs_pkg::DAY_W-1:0] >= gcs_pkg::DAY_W'(cfg.min_interval_days));

	always_comb begin
		phase_d    = phase_q;
		last_day_d = last_day_q;
		try_d      = try_q;
		send       = 1'b0;
		publish    = 1'b0;
		block      = 1'b0;
		accepted   = 1'b0;
		case (item.command)
			gcs_pkg::CMD_REQUEST: begin
				if (phase_q == gcs_pkg::PH_IDLE && age_ok) begin
					phase_d  = gcs_pkg::PH_REQUESTED;
					accepted = 1'b1;
					if (try_q != gcs_pkg::TRY_SAT)
						try_d = try_q + 1'b1;
				end
			end
			gcs_pkg::CMD_GEAR: begin
				case (phase_q)
					gcs_pkg::PH_REQUESTED: begin
						send    = 1'b1;
						phase_d = gcs_pkg::PH_SENT;
					end
					gcs_pkg::PH_SENT: begin
						if (item.gear == gcs_pkg::GEAR_RUNNING)
							phase_d = gcs_pkg::PH_RUNNING;
					end
					gcs_pkg::PH_RUNNING: begin
						if (item.gear == gcs_pkg::GEAR_DONE) begin
							last_day_d = item.day;
							try_d      = '0;
							publish    = 1'b1;
							phase_d    = gcs_pkg::PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			gcs_pkg::CMD_RESTORE: begin
				if (item.day_is_number)
					last_day_d = item.day;
			end
			gcs_pkg::CMD_TIMEOUT: begin
				if (phase_q != gcs_pkg::PH_IDLE) begin
					if (try_q < cfg.max_tries)
						phase_d = gcs_pkg::PH_IDLE;
					else
						block = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.send_calibrate    = send;
		result.publish_day_valid = publish;
		result.completed_day     = last_day_d;
		result.block_calibration = block;
		result.request_accepted  = accepted;
		result.phase             = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= gcs_pkg::PH_IDLE;
			last_day_q <= '0;
			try_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			last_day_q <= last_day_d;
			try_q      <= try_d;
		end
	end

endmodule

`default_nettype wire

### rtl/gear_calibration_sequencer.sv
// ----------------------------------------------------------------------------
// gear_calibration_sequencer: hub gear calibration scheduler
// four-phase sequencer driven by request, gear, restore and timeout events
// ----------------------------------------------------------------------------
// Each event request produces exactly one result request. The block takes one
// event per clock cycle while the result side keeps taking: an event is
// captured in the input register, its effect on the sequencer state is
// computed in one short combinational step and lands in the result register
// together with the state update. The result is offered once the event has
// passed the input register and then the result register. While a result
// waits, the input register still takes one more event, and then the event
// side stalls until the result side takes. With the result side always
// taking, the rate is one event per cycle. Configuration writes take effect
// at the next edge and are meant for moments when nothing is in flight.
// There is no clearing pass after reset.
`default_nettype none

module gear_calibration_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// event channel
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire gcs_pkg::item_t                 item,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output gcs_pkg::result_t                    result,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [gcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	gcs_pkg::item_t   item_s1;
	logic             valid_s1;
	gcs_pkg::result_t result_s2;
	logic             valid_s2;
	gcs_pkg::result_t next_result;
	gcs_pkg::cfg_t    cfg_q;
	logic             advance;
	logic             fire;

	// result register is empty or drains this cycle
	assign advance    = !valid_s2 || result_ready;
	// the held event moves into the result register, updating state
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// configuration registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_days <= gcs_pkg::MIN_INTERVAL_RST;
			cfg_q.max_tries         <= gcs_pkg::MAX_TRIES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gcs_pkg::REG_MIN_INTERVAL:
					cfg_q.min_interval_days <= cfg_wdata[gcs_pkg::MIN_W-1:0];
				gcs_pkg::REG_MAX_TRIES:
					cfg_q.max_tries <= cfg_wdata[gcs_pkg::TRY_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	// state and next-state step
	gcs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (next_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			result_s2 <= next_result;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// at most one of the pulses fires per event
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.send_calibrate, result.publish_day_valid,
			result.block_calibration, result.request_accepted}))
		else $error("more than one pulse in a result");

	// a calibrate command always leaves the sequencer in the sent phase
	a_send_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.send_calibrate) |-> (result.phase == gcs_pkg::PH_SENT))
		else $error("calibrate command without sent phase");

	// completion returns to idle and an accepted request leaves it
	a_publish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.publish_day_valid) |-> (result.phase == gcs_pkg::PH_IDLE))
		else $error("publish without return to idle");

	a_accept_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.request_accepted) |->
			(result.phase == gcs_pkg::PH_REQUESTED))
		else $error("accepted request not in requested phase");

	// blocking never happens from idle and keeps the sequencer busy
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.block_calibration) |-> (result.phase != gcs_pkg::PH_IDLE))
		else $error("block pulse while idle");

endmodule

`default_nettype wire
